// ----- design/pcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcc_pkg: shared types, constants and arithmetic helpers
// Helpers for term selection, the combine equation and the alpha path.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int unsigned CfgIdxW = 3;

  // Pixel pipe depth up to the output register
  localparam int unsigned PipeDepth = 7;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COMBINE_MODE = 3'd0,
    REG_MODE_FLAGS   = 3'd1,
    REG_PRIM_COLOR   = 3'd2,
    REG_ENV_COLOR    = 3'd3,
    REG_KEY_CS       = 3'd4,
    REG_KEY_WIDTH    = 3'd5,
    REG_CONVERT_LOD  = 3'd6
  } cfg_reg_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [55:0] combine_mode;
    logic [3:0]  mode_flags;
    logic [31:0] prim;
    logic [31:0] env;
    logic [47:0] key_cs;
    logic [35:0] key_w;
    logic [25:0] conv_lod;
  } cfg_t;

  // Per-pixel inputs carried down the pipe
  typedef struct packed {
    logic [31:0] tex0;
    logic [31:0] tex1;
    logic [31:0] shade;
    logic [7:0]  lod;
    logic [8:0]  noise0;
    logic [8:0]  noise1;
    logic [3:0]  cvg;
    logic [7:0]  dith;
  } pix_t;

  // Result of one combiner cycle
  typedef struct packed {
    logic [3:0][9:0]  color;  // floor(((A-B)*C+128)/256) + D, 10-bit signed
    logic [2:0][16:0] keyv;   // wrapped key values
    logic [2:0][8:0]  pass;   // term A of RGB
  } cyc_t;

  // Color mode flag bit positions
  localparam int unsigned FlagTwo = 0;
  localparam int unsigned FlagKey = 1;
  localparam int unsigned FlagCxa = 2;
  localparam int unsigned FlagAfc = 3;

  function automatic logic [7:0] byte_of(input logic [31:0] v, input int unsigned ch);
    byte_of = v[8*(3-ch) +: 8];
  endfunction

  // 9-bit term relative to 128, as signed 10-bit
  function automatic logic signed [9:0] ext9(input logic [8:0] v);
    logic [8:0] t;
    t = v - 9'd128;
    ext9 = $signed({t[8], t}) + 10'sd128;
  endfunction

  // clamp a 10-bit combiner value (low 9 bits taken, sign around 128)
  function automatic logic [7:0] clamp8(input logic [9:0] v);
    logic signed [9:0] e;
    e = ext9(v[8:0]);
    if (e < 0) clamp8 = 8'd0;
    else if (e > 10'sd255) clamp8 = 8'd255;
    else clamp8 = e[7:0];
  endfunction

  // Selection of one term; rows are sources 0..5, color values 9 bits
  function automatic logic [8:0] sel_term(input logic [5:0][3:0][8:0] src,
      input logic [4:0] s, input int unsigned ch, input int unsigned tm,
      input logic [8:0] noise, input logic [7:0] lod, input cfg_t cfg);
    logic [8:0] v;
    v = '0;
    if (ch == 3) begin
      if (tm == 2) begin
        if (s[2:0] == 3'd0) v = {1'b0, lod};
        else if (s[2:0] < 3'd6) v = src[s[2:0]][3];
        else if (s[2:0] == 3'd6) v = {1'b0, cfg.conv_lod[7:0]};
      end else if (s[2:0] < 3'd6) v = src[s[2:0]][3];
      else if (s[2:0] == 3'd6) v = 9'd256;
    end else if (s < 5'd6) begin
      v = src[s[2:0]][ch];
    end else if (tm == 2) begin
      if (s == 5'd6) v = {1'b0, cfg.key_cs[8*(2-ch) +: 8]};
      else if (s <= 5'd12) v = src[3'(s - 5'd7)][3];
      else if (s == 5'd13) v = {1'b0, lod};
      else if (s == 5'd14) v = {1'b0, cfg.conv_lod[7:0]};
      else if (s == 5'd15) v = cfg.conv_lod[16:8];
    end else if (tm == 1) begin
      if (s == 5'd6) v = {1'b0, cfg.key_cs[24 + 8*(2-ch) +: 8]};
      else if (s == 5'd7) v = cfg.conv_lod[25:17];
    end else if (s == 5'd6) begin
      v = 9'd256;
    end else if (tm == 0 && s == 5'd7) begin
      v = noise;
    end
    sel_term = v;
  endfunction

  // Selector field of term tm of channel ch for cycle cyc
  function automatic logic [4:0] sel_code(input logic [55:0] cm, input int unsigned cyc,
      input int unsigned ch, input int unsigned tm);
    logic [4:0] s;
    s = '0;
    if (ch == 3) begin
      case (cyc * 4 + tm)
        0: s = {2'b0, cm[46:44]};
        1: s = {2'b0, cm[14:12]};
        2: s = {2'b0, cm[43:41]};
        3: s = {2'b0, cm[11:9]};
        4: s = {2'b0, cm[23:21]};
        5: s = {2'b0, cm[5:3]};
        6: s = {2'b0, cm[20:18]};
        default: s = {2'b0, cm[2:0]};
      endcase
    end else begin
      case (cyc * 4 + tm)
        0: s = {1'b0, cm[55:52]};
        1: s = {1'b0, cm[31:28]};
        2: s = cm[51:47];
        3: s = {2'b0, cm[17:15]};
        4: s = {1'b0, cm[40:37]};
        5: s = {1'b0, cm[27:24]};
        6: s = cm[36:32];
        default: s = {2'b0, cm[8:6]};
      endcase
    end
    sel_code = s;
  endfunction

  // Key alpha from three 17-bit key values
  function automatic logic [7:0] chroma_alpha(input logic [2:0][16:0] kv,
      input logic [35:0] kw);
    logic signed [17:0] a;
    logic signed [17:0] d;
    logic signed [17:0] k;
    logic [16:0] mag;
    a = 18'sd255;
    for (int ch = 0; ch < 3; ch++) begin
      k = $signed({kv[ch][16], kv[ch]});
      mag = k[17] ? 17'(-k) : k[16:0];
      d = $signed({2'b0, kw[24 - 12*ch +: 12], 4'b0}) - $signed({1'b0, mag});
      if (d < a) a = d;
    end
    chroma_alpha = a[17] ? 8'd0 : a[7:0];
  endfunction

  // Final alpha
  function automatic logic [7:0] alpha_final(input logic [9:0] v, input logic [3:0] cvg,
      input logic [7:0] dith, input logic [3:0] fl, input logic [7:0] ka);
    logic [8:0]  a;
    logic [13:0] p;
    logic [9:0]  r;
    a = {1'b0, clamp8(v)};
    if (a == 9'd255) a = 9'd256;
    p = 14'(a) * 14'(cvg) + 14'd4;
    if (fl[FlagAfc]) r = fl[FlagCxa] ? 10'(p >> 3) : 10'({cvg, 5'b0});
    else if (fl[FlagKey]) r = {2'b0, ka};
    else r = 10'(a) + 10'(dith);
    alpha_final = (r > 10'd255) ? 8'd255 : r[7:0];
  endfunction

endpackage

// ----- design/pcc_cycle.sv -----
// ----------------------------------------------------------------------------
// pcc_cycle: one combiner cycle over three register stages
// Stage 1 selects terms, stage 2 multiplies, stage 3 adds D and key value.
// ----------------------------------------------------------------------------
module pcc_cycle (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 cyc_sel,    // 0: cycle 0 selectors, 1: cycle 1
  input  pcc_pkg::cfg_t        cfg,
  input  logic [5:0][3:0][8:0] src,
  input  logic [8:0]           noise,
  input  logic [7:0]           lod,
  output pcc_pkg::cyc_t        res
);

  logic [3:0][3:0][8:0]      t_r, t_nxt;
  logic signed [3:0][19:0]   m_r, m_nxt;
  logic [3:0][8:0]           d2_r;
  logic [2:0][8:0]           p2_r;
  pcc_pkg::cyc_t             res_r, res_nxt;

  // term selection
  always_comb begin
    for (int ch = 0; ch < 4; ch++)
      for (int tm = 0; tm < 4; tm++)
        t_nxt[ch][tm] = pcc_pkg::sel_term(src,
          pcc_pkg::sel_code(cfg.combine_mode, cyc_sel ? 1 : 0, ch, tm),
          ch, tm, noise, lod, cfg);
  end

  // (A-B)*C + 128
  always_comb begin
    logic signed [10:0] ab;
    for (int ch = 0; ch < 4; ch++) begin
      ab = 11'(pcc_pkg::ext9(t_r[ch][0])) - 11'(pcc_pkg::ext9(t_r[ch][1]));
      m_nxt[ch] = 20'(ab) * 20'($signed(t_r[ch][2])) + 20'sd128;
    end
  end

  // floor divide, add D, key value
  always_comb begin
    logic signed [9:0]  d;
    logic signed [19:0] kv;
    res_nxt = res_r;
    for (int ch = 0; ch < 4; ch++) begin
      d = pcc_pkg::ext9(d2_r[ch]);
      res_nxt.color[ch] = 10'($signed(m_r[ch]) >>> 8) + d;
      if (ch < 3) begin
        kv = m_r[ch] + 20'(d * 20'sd256);
        res_nxt.keyv[ch] = kv[16:0];
        res_nxt.pass[ch] = p2_r[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
      m_r <= m_nxt;
      for (int ch = 0; ch < 4; ch++) d2_r[ch] <= t_r[ch][3];
      for (int ch = 0; ch < 3; ch++) p2_r[ch] <= t_r[ch][0];
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- design/pixel_color_combiner.sv -----
// ----------------------------------------------------------------------------
// pixel_color_combiner: pixel color combiner, cycle-0 combiner followed by cycle-1 combiner
// Streaming pipeline computing (A-B)*C+D per channel with key and coverage.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one pixel item per cycle while in_tready is high; tdata fields
//    low to high: texel_zero, texel_one, shade_color, lod_frac, noise_first_cycle,
//    noise_second_cycle, coverage_in, dither_value, two zero pad bits.
//  - out_*: one result item per pixel; tdata low to high: red_out, green_out,
//    blue_out, alpha_out, coverage_out, compare alpha, four zero pad bits.
//  - cfg_*: register writes (index, data); cfg_ready is always high, write
//    only while no item is in flight.
// Pipeline: three stages per combiner cycle, one alignment stage between the two,
// then the output register. Throughput: one item per cycle unless the receiver stalls;
// every stage takes a new item each cycle the pipe is enabled.
// Reset clears all valid bits and the configuration registers to zero.
// When the receiver stalls the whole pipe holds; in_tready drops while the
// output register holds an item not taken, so a stall loses nothing.
// ----------------------------------------------------------------------------
module pixel_color_combiner (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // tex0, tex1, shade, lod, noise0, noise1, cvg, dith, pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // red, green, blue, alpha, cvg(4), compare alpha, pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  pcc_pkg::cfg_t cfg_r;
  logic          en;
  logic [pcc_pkg::PipeDepth-1:0] vld_r;
  pcc_pkg::pix_t pix_r [pcc_pkg::PipeDepth];
  pcc_pkg::pix_t pix_in;
  logic [5:0][3:0][8:0] src0, src1;
  pcc_pkg::cyc_t c0_res, c1_res;
  logic [3:0][9:0] comb_r;
  logic [7:0] ka0_r;
  logic [47:0] out_nxt;
  logic out_vld_r;

  assign cfg_ready = 1'b1;
  assign en = !out_vld_r || out_tready;
  assign in_tready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (pcc_pkg::cfg_reg_t'(cfg_index))
        pcc_pkg::REG_COMBINE_MODE: cfg_r.combine_mode <= cfg_data[55:0];
        pcc_pkg::REG_MODE_FLAGS:   cfg_r.mode_flags <= cfg_data[3:0];
        pcc_pkg::REG_PRIM_COLOR:   cfg_r.prim <= cfg_data[31:0];
        pcc_pkg::REG_ENV_COLOR:    cfg_r.env <= cfg_data[31:0];
        pcc_pkg::REG_KEY_CS:       cfg_r.key_cs <= cfg_data[47:0];
        pcc_pkg::REG_KEY_WIDTH:    cfg_r.key_w <= cfg_data[35:0];
        pcc_pkg::REG_CONVERT_LOD:  cfg_r.conv_lod <= cfg_data[25:0];
        default: ;
      endcase
    end
  end

  // unpack tdata (lowest field first) into struct member order
  assign pix_in = {in_tdata[31:0], in_tdata[63:32], in_tdata[95:64], in_tdata[103:96],
                   in_tdata[112:104], in_tdata[121:113], in_tdata[125:122],
                   in_tdata[133:126]};

  // pixel side-band pipe and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[pcc_pkg::PipeDepth-2:0], in_tvalid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pix_r[0] <= pix_in;
      for (int i = 1; i < pcc_pkg::PipeDepth; i++) pix_r[i] <= pix_r[i-1];
    end
  end

  // cycle 0 sources, combined color zero
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      src0[0][ch] = '0;
      src0[1][ch] = {1'b0, pcc_pkg::byte_of(pix_in.tex0, ch)};
      src0[2][ch] = {1'b0, pcc_pkg::byte_of(pix_in.tex1, ch)};
      src0[3][ch] = {1'b0, pcc_pkg::byte_of(cfg_r.prim, ch)};
      src0[4][ch] = {1'b0, pcc_pkg::byte_of(pix_in.shade, ch)};
      src0[5][ch] = {1'b0, pcc_pkg::byte_of(cfg_r.env, ch)};
    end
  end

  pcc_cycle u_cyc0 (
    .clk(clk), .en(en), .cyc_sel(1'b0), .cfg(cfg_r),
    .src(src0), .noise(pix_in.noise0), .lod(pix_in.lod), .res(c0_res)
  );

  // stage 4: keep cycle-0 color (zero when FlagTwo is clear) and key alpha
  always_ff @(posedge clk) begin
    if (en) begin
      comb_r <= cfg_r.mode_flags[pcc_pkg::FlagTwo] ? c0_res.color : '0;
      ka0_r  <= pcc_pkg::chroma_alpha(c0_res.keyv, cfg_r.key_w);
    end
  end

  // cycle 1 sources; texels swapped when FlagTwo is set
  always_comb begin
    logic two;
    two = cfg_r.mode_flags[pcc_pkg::FlagTwo];
    for (int ch = 0; ch < 4; ch++) begin
      src1[0][ch] = comb_r[ch][8:0];
      src1[1][ch] = {1'b0, pcc_pkg::byte_of(two ? pix_r[3].tex1 : pix_r[3].tex0, ch)};
      src1[2][ch] = {1'b0, pcc_pkg::byte_of(two ? pix_r[3].tex0 : pix_r[3].tex1, ch)};
      src1[3][ch] = {1'b0, pcc_pkg::byte_of(cfg_r.prim, ch)};
      src1[4][ch] = {1'b0, pcc_pkg::byte_of(pix_r[3].shade, ch)};
      src1[5][ch] = {1'b0, pcc_pkg::byte_of(cfg_r.env, ch)};
    end
  end

  // test alpha of cycle 0 travels alongside cycle 1
  logic [7:0] test_d_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      test_d_r[0] <= pcc_pkg::alpha_final(comb_r[3], pix_r[3].cvg, pix_r[3].dith,
                       cfg_r.mode_flags, ka0_r);
      test_d_r[1] <= test_d_r[0];
      test_d_r[2] <= test_d_r[1];
    end
  end

  pcc_cycle u_cyc1 (
    .clk(clk), .en(en), .cyc_sel(1'b1), .cfg(cfg_r),
    .src(src1), .noise(pix_r[3].noise1), .lod(pix_r[3].lod), .res(c1_res)
  );

  // final stage into the output register
  always_comb begin
    logic [7:0] al, c8, ta;
    logic [8:0] c;
    logic [12:0] p;
    logic [3:0] co;
    logic key;
    key = cfg_r.mode_flags[pcc_pkg::FlagKey];
    al = pcc_pkg::alpha_final(c1_res.color[3], pix_r[6].cvg, pix_r[6].dith,
           cfg_r.mode_flags, pcc_pkg::chroma_alpha(c1_res.keyv, cfg_r.key_w));
    c8 = pcc_pkg::clamp8(c1_res.color[3]);
    c = (c8 == 8'd255) ? 9'd256 : {1'b0, c8};
    p = 13'(c) * 13'(pix_r[6].cvg) + 13'd4;
    co = cfg_r.mode_flags[pcc_pkg::FlagCxa] ? 4'(p >> 8) : pix_r[6].cvg;
    ta = cfg_r.mode_flags[pcc_pkg::FlagTwo] ? test_d_r[2] : al;
    for (int ch = 0; ch < 3; ch++)
      out_nxt[8*ch +: 8] = pcc_pkg::clamp8(key ? {1'b0, c1_res.pass[ch]} : c1_res.color[ch]);
    out_nxt[31:24] = al;
    out_nxt[35:32] = co;
    out_nxt[43:36] = ta;
    out_nxt[47:44] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[pcc_pkg::PipeDepth-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) out_tdata <= out_nxt;
  end
  assign out_tvalid = out_vld_r;

  // a stalled result holds its valid
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  // no acceptance while stalled with a full output
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready) else $error("accept during stall");
  // pipe advances only when enabled
  a_vld: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r)) else $error("valid moved while stalled");

endmodule
